// ----- rtl/core/leg_force_pi_torque_controller_macros.svh -----
// assertion macros for the leg force controller checker
`ifndef LEG_FORCE_PI_TORQUE_CONTROLLER_MACROS_SVH
`define LEG_FORCE_PI_TORQUE_CONTROLLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LFPC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define LFPC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lfpc_pkg.sv -----
// types, constants and helper functions of the leg force controller
package lfpc_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TORQUE_LIMIT = 3'd0,
        CFG_PROP_GAIN    = 3'd1,
        CFG_INT_GAIN     = 3'd2,
        CFG_TIME_STEP    = 3'd3,
        CFG_LINK_LENGTH  = 3'd4
    } cfg_index_t;

    localparam logic [14:0] TORQUE_LIMIT_RST = 15'd2816;
    localparam logic [15:0] PROP_GAIN_RST    = 16'd128;
    localparam logic [15:0] INT_GAIN_RST     = 16'd512;
    localparam logic [15:0] TIME_STEP_RST    = 16'd66;
    localparam logic [15:0] LINK_LENGTH_RST  = 16'd15073;

    localparam logic signed [17:0] PI_Q13      = 18'sd25736;
    localparam logic signed [17:0] HALF_PI_Q13 = 18'sd12868;
    localparam logic signed [17:0] TWO_PI_Q13  = 18'sd51472;
    localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

    localparam int ACC_W = 58;
    localparam int Z_W   = 28;
    localparam int XY_W  = 32;

    typedef struct packed {
        logic [15:0] value;
        logic        clamped;
    } clamp_t;

    // arctan(2^-i) in units of 2^-24 rad
    function automatic logic signed [Z_W-1:0] atan_q24(input logic [4:0] idx);
        logic signed [Z_W-1:0] r;
        r = '0;
        case (idx)
            5'd0:  r = 28'sd13176795;
            5'd1:  r = 28'sd7778716;
            5'd2:  r = 28'sd4110060;
            5'd3:  r = 28'sd2086331;
            5'd4:  r = 28'sd1047214;
            5'd5:  r = 28'sd524117;
            5'd6:  r = 28'sd262123;
            5'd7:  r = 28'sd131069;
            5'd8:  r = 28'sd65536;
            5'd9:  r = 28'sd32768;
            5'd10: r = 28'sd16384;
            5'd11: r = 28'sd8192;
            5'd12: r = 28'sd4096;
            5'd13: r = 28'sd2048;
            5'd14: r = 28'sd1024;
            5'd15: r = 28'sd512;
            5'd16: r = 28'sd256;
            5'd17: r = 28'sd128;
            5'd18: r = 28'sd64;
            5'd19: r = 28'sd32;
            5'd20: r = 28'sd16;
            5'd21: r = 28'sd8;
            5'd22: r = 28'sd4;
            5'd23: r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // wrap into (-pi, pi], fold into [-pi/2, pi/2], scale Q13 to 2^-24 rad
    function automatic logic signed [Z_W-1:0] angle_to_z(input logic signed [16:0] ang);
        logic signed [17:0] a;
        a = 18'(ang);
        if (a > PI_Q13) begin
            a = a - TWO_PI_Q13;
        end else if (a <= -PI_Q13) begin
            a = a + TWO_PI_Q13;
        end
        if (a > HALF_PI_Q13) begin
            a = PI_Q13 - a;
        end else if (a < -HALF_PI_Q13) begin
            a = -PI_Q13 - a;
        end
        return Z_W'(a) <<< 11;
    endfunction

    function automatic clamp_t clamp_torque(input logic signed [27:0] t,
                                            input logic [14:0] lim);
        logic signed [27:0] lp;
        clamp_t r;
        lp = signed'(28'(lim));
        if (t > lp) begin
            r.value   = lp[15:0];
            r.clamped = 1'b1;
        end else if (t < -lp) begin
            r.value   = 16'(-lp);
            r.clamped = 1'b1;
        end else begin
            r.value   = t[15:0];
            r.clamped = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/leg_force_pi_torque_controller.sv -----
// leg vertical force pi controller with jacobian transpose torque output
//
// input word (s_axis): tdata holds hip_angle, knee_angle (Q2.13 rad),
// desired_force and estimated_force (1/256 N); tuser is ready_state.
// output word (m_axis): hip_torque, knee_torque (1/256 N*m) and clamp_flags.
// one output word per input word, in order.
// configuration is written through cfg_we / cfg_addr / cfg_wdata; the user
// must write it only while idle, the block itself does not enforce this.
// all products go through one shift-add multiplier that takes one multiplier
// bit per cycle: three 16-bit products for the integrator and pi terms, two
// 16-bit products for the jacobian and two 24-bit products for the torques,
// each followed by a collect step. both sines come from one cordic stage that
// runs CORDIC_STEPS iterations, one per cycle. once a result is loaded into
// the output register the controller returns to idle and takes the next word.
// s_axis_tready is high only while no item is in work; a finished result
// may still wait in the output register while the next word is accepted.
// if the receiver stalls, the following result holds until the register frees.
// reset (aresetn low, synchronous) loads register defaults, clears the
// integrator and empties the output register.
module leg_force_pi_torque_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // hip_angle[15:0], knee_angle[31:16], desired_force[55:32], estimated_force[79:56]
    input  logic [79:0]                      s_axis_tdata,
    // ready_state[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // hip_torque[15:0], knee_torque[31:16], clamp_flags[33:32], zeros above
    output logic [39:0]                      m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [lfpc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lfpc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import lfpc_pkg::*;

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_INTEG, ST_PROP, ST_IGAIN, ST_SIN1, ST_SIN2,
        ST_JAC1, ST_JAC2, ST_TRQ1, ST_TRQ2, ST_OUT
    } state_t;

    state_t state_reg;

    logic [14:0] torque_limit_reg;
    logic [15:0] prop_gain_reg, int_gain_reg, time_step_reg, link_length_reg;
    logic signed [39:0] integ_reg;

    logic signed [15:0] hip_reg, knee_reg;
    logic signed [23:0] fd_reg;
    logic               ready_reg;
    logic signed [32:0] p_reg;
    logic signed [23:0] f_reg;
    logic signed [XY_W-1:0] s1_reg, s12_reg;
    logic signed [19:0] j1_reg, j2_reg;
    logic signed [27:0] t1_reg, t2_reg;

    logic signed [ACC_W-1:0] mul_a_reg, mul_acc_reg;
    logic [23:0] mul_b_reg;
    logic [4:0]  mul_cnt_reg;
    logic        mul_sgn_reg;

    logic signed [XY_W-1:0] cx_reg, cy_reg;
    logic signed [Z_W-1:0]  cz_reg;
    logic [STEP_W-1:0]      ci_reg;

    logic [39:0] m_data_reg;
    logic        m_valid_reg;

    // input field views
    logic signed [15:0] hip_in, knee_in;
    logic signed [23:0] fd_in, fe_in;
    logic signed [24:0] err_in;
    assign hip_in  = s_axis_tdata[15:0];
    assign knee_in = s_axis_tdata[31:16];
    assign fd_in   = s_axis_tdata[55:32];
    assign fe_in   = s_axis_tdata[79:56];
    assign err_in  = 25'(fd_in) - 25'(fe_in);

    // shift-add step, msb of a signed multiplier carries negative weight
    logic signed [ACC_W-1:0] mul_part, mul_acc_next;
    always_comb begin
        mul_part = mul_b_reg[0] ? mul_a_reg : '0;
        if (mul_sgn_reg && mul_cnt_reg == 5'd1) begin
            mul_acc_next = mul_acc_reg - mul_part;
        end else begin
            mul_acc_next = mul_acc_reg + mul_part;
        end
    end

    // cordic rotation step
    logic signed [XY_W-1:0] cx_next, cy_next;
    logic signed [Z_W-1:0]  cz_next, atan_v;
    always_comb begin
        atan_v = atan_q24(5'(ci_reg));
        if (cz_reg >= 0) begin
            cx_next = cx_reg - (cy_reg >>> ci_reg);
            cy_next = cy_reg + (cx_reg >>> ci_reg);
            cz_next = cz_reg - atan_v;
        end else begin
            cx_next = cx_reg + (cy_reg >>> ci_reg);
            cy_next = cy_reg - (cx_reg >>> ci_reg);
            cz_next = cz_reg + atan_v;
        end
    end

    // result collection
    logic signed [40:0] prod_err_ts;
    logic signed [41:0] integ_sum;
    logic signed [39:0] integ_next;
    logic signed [31:0] i_term;
    logic signed [34:0] f_sum;
    logic signed [23:0] f_next;
    logic signed [18:0] jac_raw;
    clamp_t hip_cl, knee_cl;
    always_comb begin
        prod_err_ts = mul_acc_reg[40:0];
        integ_sum   = 42'(integ_reg) + 42'(prod_err_ts);
        if (integ_sum > 42'sd549755813887) begin
            integ_next = 40'sh7F_FFFF_FFFF;
        end else if (integ_sum < -42'sd549755813888) begin
            integ_next = 40'sh80_0000_0000;
        end else begin
            integ_next = integ_sum[39:0];
        end
        i_term = mul_acc_reg[55:24];
        f_sum  = 35'(fd_reg) + 35'(p_reg) + 35'(i_term);
        if (f_sum > 35'sd8388607) begin
            f_next = 24'sh7F_FFFF;
        end else if (f_sum < -35'sd8388608) begin
            f_next = 24'sh80_0000;
        end else begin
            f_next = f_sum[23:0];
        end
        jac_raw = mul_acc_reg[48:30];
        hip_cl  = clamp_torque(t1_reg, torque_limit_reg);
        knee_cl = clamp_torque(t2_reg, torque_limit_reg);
    end

    // output register takes the finished word once it is free
    logic out_load;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            torque_limit_reg <= TORQUE_LIMIT_RST;
            prop_gain_reg    <= PROP_GAIN_RST;
            int_gain_reg     <= INT_GAIN_RST;
            time_step_reg    <= TIME_STEP_RST;
            link_length_reg  <= LINK_LENGTH_RST;
            integ_reg        <= '0;
            m_valid_reg      <= 1'b0;
            mul_cnt_reg      <= '0;
            ci_reg           <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index_t'(cfg_addr))
                    CFG_TORQUE_LIMIT: torque_limit_reg <= cfg_wdata[14:0];
                    CFG_PROP_GAIN:    prop_gain_reg    <= cfg_wdata;
                    CFG_INT_GAIN:     int_gain_reg     <= cfg_wdata;
                    CFG_TIME_STEP:    time_step_reg    <= cfg_wdata;
                    CFG_LINK_LENGTH:  link_length_reg  <= cfg_wdata;
                    default: ;
                endcase
            end

            if (out_load) begin
                m_valid_reg <= 1'b1;
                if (ready_reg) begin
                    m_data_reg <= '0;
                end else begin
                    m_data_reg <= {6'b0, knee_cl.clamped, hip_cl.clamped,
                                   knee_cl.value, hip_cl.value};
                end
            end else if (m_valid_reg && m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        hip_reg     <= hip_in;
                        knee_reg    <= knee_in;
                        fd_reg      <= fd_in;
                        ready_reg   <= s_axis_tuser[0];
                        mul_a_reg   <= ACC_W'(err_in);
                        mul_b_reg   <= 24'(time_step_reg);
                        mul_cnt_reg <= 5'd16;
                        mul_sgn_reg <= 1'b0;
                        mul_acc_reg <= '0;
                        state_reg   <= ST_INTEG;
                    end
                end
                ST_INTEG, ST_PROP, ST_IGAIN, ST_JAC1, ST_JAC2, ST_TRQ1, ST_TRQ2: begin
                    if (mul_cnt_reg != 5'd0) begin
                        mul_acc_reg <= mul_acc_next;
                        mul_a_reg   <= mul_a_reg <<< 1;
                        mul_b_reg   <= mul_b_reg >> 1;
                        mul_cnt_reg <= mul_cnt_reg - 5'd1;
                    end else begin
                        mul_acc_reg <= '0;
                        case (state_reg)
                            ST_INTEG: begin
                                integ_reg   <= integ_next;
                                mul_a_reg   <= ACC_W'(mul_a_reg >>> 16);
                                mul_b_reg   <= 24'(prop_gain_reg);
                                mul_cnt_reg <= 5'd16;
                                mul_sgn_reg <= 1'b0;
                                state_reg   <= ST_PROP;
                            end
                            ST_PROP: begin
                                p_reg       <= mul_acc_reg[40:8];
                                mul_a_reg   <= ACC_W'(integ_reg);
                                mul_b_reg   <= 24'(int_gain_reg);
                                mul_cnt_reg <= 5'd16;
                                mul_sgn_reg <= 1'b0;
                                state_reg   <= ST_IGAIN;
                            end
                            ST_IGAIN: begin
                                f_reg     <= f_next;
                                cx_reg    <= CORDIC_GAIN_Q30;
                                cy_reg    <= '0;
                                cz_reg    <= angle_to_z(17'(hip_reg));
                                ci_reg    <= '0;
                                state_reg <= ST_SIN1;
                            end
                            ST_JAC1: begin
                                j1_reg      <= -(20'(jac_raw));
                                mul_a_reg   <= ACC_W'(s12_reg);
                                mul_b_reg   <= 24'(link_length_reg);
                                mul_cnt_reg <= 5'd16;
                                mul_sgn_reg <= 1'b0;
                                state_reg   <= ST_JAC2;
                            end
                            ST_JAC2: begin
                                j2_reg      <= -(20'(jac_raw));
                                mul_a_reg   <= ACC_W'(j1_reg);
                                mul_b_reg   <= f_reg;
                                mul_cnt_reg <= 5'd24;
                                mul_sgn_reg <= 1'b1;
                                state_reg   <= ST_TRQ1;
                            end
                            ST_TRQ1: begin
                                t1_reg      <= mul_acc_reg[43:16];
                                mul_a_reg   <= ACC_W'(j2_reg);
                                mul_b_reg   <= f_reg;
                                mul_cnt_reg <= 5'd24;
                                mul_sgn_reg <= 1'b1;
                                state_reg   <= ST_TRQ2;
                            end
                            default: begin
                                // knee product done, hold it for the output word
                                t2_reg    <= mul_acc_reg[43:16];
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_SIN1, ST_SIN2: begin
                    if (ci_reg == LAST_STEP) begin
                        ci_reg <= '0;
                        if (state_reg == ST_SIN1) begin
                            s1_reg    <= cy_next;
                            cx_reg    <= CORDIC_GAIN_Q30;
                            cy_reg    <= '0;
                            cz_reg    <= angle_to_z(17'(hip_reg) + 17'(knee_reg));
                            state_reg <= ST_SIN2;
                        end else begin
                            s12_reg     <= cy_next;
                            mul_a_reg   <= ACC_W'(s1_reg) + ACC_W'(cy_next);
                            mul_b_reg   <= 24'(link_length_reg);
                            mul_cnt_reg <= 5'd16;
                            mul_sgn_reg <= 1'b0;
                            mul_acc_reg <= '0;
                            state_reg   <= ST_JAC1;
                        end
                    end else begin
                        cx_reg <= cx_next;
                        cy_reg <= cy_next;
                        cz_reg <= cz_next;
                        ci_reg <= ci_reg + STEP_W'(1);
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- rtl/core/lfpc_checker.sv -----
// port-level checker for the leg force controller, bound to the top level
`include "leg_force_pi_torque_controller_macros.svh"

module lfpc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);
    // a stalled result word holds
    `LFPC_ASSERT_NXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed under stall")
    // one item in work at a time
    `LFPC_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
    // a result only appears at the end of the work on an item
    `LFPC_ASSERT_IMP(a_result_from_work, aclk, aresetn, $rose(m_axis_tvalid), $past(!s_axis_tready), "result without work")
endmodule

bind leg_force_pi_torque_controller lfpc_checker u_lfpc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- sim/leg_force_pi_torque_controller_checker.sv -----
// checker for the leg force controller: predicts torques and compares output words
module leg_force_pi_torque_controller_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,
    input  logic [0:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [lfpc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lfpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int          fail_count,
    output int          torques_pending,
    output int          torques_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import lfpc_pkg::*;

    localparam int STEPS = 16;
    localparam longint INTEG_MAX = 64'sd549755813887;
    localparam longint INTEG_MIN = -64'sd549755813888;

    typedef struct {
        logic signed [15:0] hip;
        logic signed [15:0] knee;
        logic [1:0]         flags;
    } torque_word_t;

    torque_word_t torque_q[$];

    logic [14:0] lim;
    logic [15:0] kp, ki, dt, link;
    longint      integ;

    longint atan_lut [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2};

    function automatic longint sine_of(longint a);
        longint x, y, z, nx;
        x = 652032874;
        y = 0;
        if (a > 25736) a -= 51472;
        else if (a <= -25736) a += 51472;
        if (a > 12868) a = 25736 - a;
        else if (a < -12868) a = -25736 - a;
        z = a * 2048;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= atan_lut[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += atan_lut[i];
            end
            x = nx;
        end
        return y;
    endfunction

    // advances the integrator and returns the torque word for one tick
    function automatic torque_word_t torque_for(logic [79:0] d, logic rdy);
        torque_word_t w;
        longint hip, knee, fd, fe, err, f, s1, s12, j1, j2, t1, t2, l;
        hip  = longint'($signed(d[15:0]));
        knee = longint'($signed(d[31:16]));
        fd   = longint'($signed(d[55:32]));
        fe   = longint'($signed(d[79:56]));
        err  = fd - fe;
        integ = integ + err * longint'(dt);
        if (integ > INTEG_MAX) integ = INTEG_MAX;
        if (integ < INTEG_MIN) integ = INTEG_MIN;
        f = fd + ((err * longint'(kp)) >>> 8) + ((integ * longint'(ki)) >>> 24);
        if (f > 8388607) f = 8388607;
        if (f < -8388608) f = -8388608;
        s1  = sine_of(hip);
        s12 = sine_of(hip + knee);
        j1 = -(((s1 + s12) * longint'(link)) >>> 30);
        j2 = -((s12 * longint'(link)) >>> 30);
        t1 = (j1 * f) >>> 16;
        t2 = (j2 * f) >>> 16;
        l  = longint'(lim);
        w.flags = 2'b00;
        if (rdy) begin
            t1 = 0;
            t2 = 0;
        end else begin
            if (t1 > l) begin t1 = l; w.flags[0] = 1'b1; end
            else if (t1 < -l) begin t1 = -l; w.flags[0] = 1'b1; end
            if (t2 > l) begin t2 = l; w.flags[1] = 1'b1; end
            else if (t2 < -l) begin t2 = -l; w.flags[1] = 1'b1; end
        end
        w.hip  = t1[15:0];
        w.knee = t2[15:0];
        return w;
    endfunction

    always @(posedge aclk) begin
        torque_word_t exp_w;
        if (!aresetn) begin
            lim   = TORQUE_LIMIT_RST;
            kp    = PROP_GAIN_RST;
            ki    = INT_GAIN_RST;
            dt    = TIME_STEP_RST;
            link  = LINK_LENGTH_RST;
            integ = 0;
            torque_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_TORQUE_LIMIT: lim  = cfg_wdata[14:0];
                    CFG_PROP_GAIN:    kp   = cfg_wdata;
                    CFG_INT_GAIN:     ki   = cfg_wdata;
                    CFG_TIME_STEP:    dt   = cfg_wdata;
                    CFG_LINK_LENGTH:  link = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                torque_q.push_back(torque_for(s_axis_tdata, s_axis_tuser[0]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (torque_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output word %h", m_axis_tdata);
                end else begin
                    exp_w = torque_q.pop_front();
                    torques_checked++;
                    if (m_axis_tdata[15:0] !== exp_w.hip || m_axis_tdata[31:16] !== exp_w.knee
                            || m_axis_tdata[33:32] !== exp_w.flags) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: hip %0d/%0d knee %0d/%0d flags %b/%b (exp/got)",
                                exp_w.hip, $signed(m_axis_tdata[15:0]), exp_w.knee,
                                $signed(m_axis_tdata[31:16]), exp_w.flags,
                                m_axis_tdata[33:32]);
                    end
                end
            end
        end
        torques_pending = torque_q.size();
    end

    initial begin
        fail_count = 0;
        torques_pending = 0;
        torques_checked = 0;
    end
endmodule

// ----- sim/tb_leg_force_pi_torque_controller.sv -----
// testbench top for the leg force controller: stimulus, flow control and verdict
module tb_leg_force_pi_torque_controller;
    timeunit 1ns;
    timeprecision 1ps;
    import lfpc_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;
    localparam int PHASE_ITEMS = 172;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count, torques_pending, torques_checked;
    int tx_idle_pct = 16;
    int rx_idle_pct = 88;
    bit rx_hold = 1'b0;
    int words_sent = 0;
    int settings_run = 1;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    leg_force_pi_torque_controller dut (.*);

    leg_force_pi_torque_controller_checker chk (
        .aclk, .aresetn, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we, .cfg_addr, .cfg_wdata,
        .fail_count, .torques_pending, .torques_checked
    );

    always @(posedge aclk)
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    task automatic send_word(logic [15:0] hip, logic [15:0] knee, logic [23:0] fd,
                             logic [23:0] fe, logic rdy);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {fe, fd, knee, hip};
        s_axis_tuser  <= rdy;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        words_sent++;
    endtask

    function automatic logic [23:0] pick_force();
        if ($urandom_range(2) == 0) return 24'($urandom);
        return 24'($signed($urandom_range(8191)) - 4096);
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
            send_word(16'($urandom), 16'($urandom), pick_force(), pick_force(),
                      $urandom_range(6) == 0);
        s_axis_tvalid <= 1'b0;
    endtask

    // wait until every word has come back, then let the pipeline settle
    task automatic drain();
        @(posedge aclk);
        while (torques_pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic set_all(logic [15:0] lim, logic [15:0] kp, logic [15:0] ki,
                           logic [15:0] dt, logic [15:0] len);
        cfg_write(CFG_TORQUE_LIMIT, lim);
        cfg_write(CFG_PROP_GAIN, kp);
        cfg_write(CFG_INT_GAIN, ki);
        cfg_write(CFG_TIME_STEP, dt);
        cfg_write(CFG_LINK_LENGTH, len);
        cfg_we <= 1'b0;
        settings_run++;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: angle and force extremes, ready state, zero error
        send_word(16'h0000, 16'h0000, 24'd0, 24'd0, 1'b0);
        send_word(16'h7fff, 16'h7fff, 24'h7fffff, 24'h800000, 1'b0);
        send_word(16'h8000, 16'h8000, 24'h800000, 24'h7fffff, 1'b0);
        send_word(16'h8000, 16'h7fff, 24'h7fffff, 24'h7fffff, 1'b0);
        send_word(16'd12868, 16'd0, 24'd100000, 24'd0, 1'b0);
        send_word(-16'sd12868, 16'd25736, 24'd100000, 24'd50000, 1'b0);
        send_word(16'd25736, 16'd25736, -24'sd200000, 24'd0, 1'b0);
        send_word(-16'sd25736, -16'sd25736, 24'd3000, 24'd1000, 1'b0);
        send_word(16'd12869, -16'sd12869, 24'd50000, -24'sd50000, 1'b0);
        send_word(16'h7fff, 16'h0000, 24'h7fffff, 24'h800000, 1'b1);
        send_word(16'h4000, 16'h2000, 24'd40000, 24'd0, 1'b1);
        send_word(16'h4000, 16'h2000, 24'd40000, 24'd0, 1'b0);
        send_word(16'hc000, 16'hffff, 24'hffffff, 24'h000001, 1'b0);
        s_axis_tvalid <= 1'b0;
        drain();

        // gains and limit at their tops: integrator and force saturate
        set_all(16'd32767, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_word(16'h3000, 16'h1000, 24'h7fffff, 24'h800000, 1'b0);
        send_word(16'h3000, 16'h1000, 24'h7fffff, 24'h800000, 1'b1);
        send_word(16'hd000, 16'h1000, 24'h800000, 24'h7fffff, 1'b0);
        send_random(PHASE_ITEMS);
        drain();

        // everything zero, plus a write to an unused index that must be ignored
        set_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        cfg_write(CFG_UNUSED, 16'hffff);
        cfg_we <= 1'b0;
        tx_idle_pct = 88;
        rx_idle_pct = 16;
        send_word(16'h2000, 16'h2000, 24'd5000, 24'd0, 1'b0);
        send_random(PHASE_ITEMS);
        drain();

        // receiver holds off for a long stretch while words keep coming
        set_all(16'd1000, 16'd300, 16'd1000, 16'd2000, 16'd30000);
        tx_idle_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (1500) @(posedge aclk);
                rx_hold = 1'b0;
            end
        join_none
        send_random(PHASE_ITEMS);
        drain();

        set_all(16'($urandom_range(32767)), 16'($urandom), 16'($urandom),
                16'($urandom_range(4000)), 16'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(PHASE_ITEMS);
        drain();

        set_all(16'(TORQUE_LIMIT_RST), PROP_GAIN_RST, INT_GAIN_RST, TIME_STEP_RST,
                LINK_LENGTH_RST);
        send_random(PHASE_ITEMS);
        drain();

        set_all(16'd300, 16'd1024, 16'd4096, 16'd500, 16'd20000);
        send_random(PHASE_ITEMS);
        drain();

        $display("sent %0d words and checked %0d torque words over %0d register settings,",
                 words_sent, torques_checked, settings_run);
        $display("with sender and receiver stalls, a long output hold-off and saturation cases");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #12ms;
        $display("timeout waiting for the controller");
        $display("status: fail");
        $finish;
    end
endmodule

// ----- leg_force_pi_torque_controller.f -----
+incdir+rtl/core
rtl/core/lfpc_pkg.sv
rtl/core/leg_force_pi_torque_controller.sv
rtl/core/lfpc_checker.sv
sim/leg_force_pi_torque_controller_checker.sv
sim/tb_leg_force_pi_torque_controller.sv
